FILE: rtl/system_table_header_validator_defines.svh
// assertion helpers shared by the validator rtl
`ifndef SYSTEM_TABLE_HEADER_VALIDATOR_DEFINES_SVH
`define SYSTEM_TABLE_HEADER_VALIDATOR_DEFINES_SVH

// same-cycle implication, checked outside reset
`define STHV_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define STHV_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/sthv_pkg.sv
package sthv_pkg;

   // verdict codes
   typedef enum logic [2:0] {
      CAUSE_NONE         = 3'd0,
      CAUSE_SIG_MISMATCH = 3'd1,
      CAUSE_BAD_CHAR     = 3'd2,
      CAUSE_TOO_SMALL    = 3'd3,
      CAUSE_CHECKSUM     = 3'd4,
      CAUSE_TRUNCATED    = 3'd5
   } fail_cause_type;

   // register indexes
   typedef enum logic [0:0] {
      CSR_MATCH_MODE   = 1'b0,
      CSR_EXPECTED_SIG = 1'b1
   } csr_index_type;

   // "OEM" as captured, first character in the low byte
   localparam logic [23:0] OEM_PREFIX = 24'h4D454F;
   localparam logic [31:0] OFFSET_MAX = 32'hFFFF_FFFF;
   localparam logic [7:0]  CHAR_UNDERSCORE = 8'h5F;
   localparam logic [7:0]  CHAR_BANG       = 8'h21;

   // per-table tracking state
   typedef struct packed {
      logic [31:0] byte_offset;
      logic [31:0] signature;
      logic [31:0] length;
      logic [7:0]  sum;
      logic        bad_char;
   } table_state_type;

   // one result transaction
   typedef struct packed {
      logic           table_ok;
      fail_cause_type fail_cause;
      logic           oem_table;
      logic [31:0]    table_length;
   } verdict_type;

   // letters, underscore and exclamation mark are legal signature characters
   function automatic logic sig_char_ok(input logic [7:0] c);
      logic ok;
      ok = ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A)) ||
           (c == CHAR_UNDERSCORE) || (c == CHAR_BANG);
      return ok;
   endfunction

endpackage

FILE: rtl/sthv_verdict.sv
module sthv_verdict #(
   parameter int HEADER_BYTES = 36
) (
   input  sthv_pkg::table_state_type cur,
   input  logic [7:0]                table_byte,
   input  logic                      match_mode,
   input  logic [31:0]               expected_signature,
   output sthv_pkg::table_state_type upd,
   output sthv_pkg::verdict_type     verdict
);

   logic [31:0] off;
   logic [32:0] total;
   logic        oem;
   sthv_pkg::fail_cause_type cause;

   assign off   = cur.byte_offset;
   assign total = {1'b0, off} + 33'd1;

   // fold this byte into the tracking state
   always_comb begin
      upd = cur;
      if (off[31:2] == 30'd0) begin
         upd.signature = cur.signature | ({24'd0, table_byte} << {off[1:0], 3'b000});
         if (!sthv_pkg::sig_char_ok(table_byte)) begin
            upd.bad_char = 1'b1;
         end
      end else if (off[31:3] == 29'd0) begin
         upd.length = cur.length | ({24'd0, table_byte} << {off[1:0], 3'b000});
      end
      if ((off[31:3] == 29'd0) || (off < cur.length)) begin
         upd.sum = cur.sum + table_byte;
      end
      if (off != sthv_pkg::OFFSET_MAX) begin
         upd.byte_offset = off + 32'd1;
      end
   end

   assign oem = (total >= 33'd3) && (upd.signature[23:0] == sthv_pkg::OEM_PREFIX);

   // checks in priority order, on the state including this byte
   always_comb begin
      if (total < 33'd4) begin
         cause = sthv_pkg::CAUSE_TRUNCATED;
      end else if (match_mode && (upd.signature != expected_signature)) begin
         cause = sthv_pkg::CAUSE_SIG_MISMATCH;
      end else if (!match_mode && upd.bad_char) begin
         cause = sthv_pkg::CAUSE_BAD_CHAR;
      end else if (total < 33'd8) begin
         cause = sthv_pkg::CAUSE_TRUNCATED;
      end else if (upd.length < 32'(HEADER_BYTES)) begin
         cause = sthv_pkg::CAUSE_TOO_SMALL;
      end else if (total < {1'b0, upd.length}) begin
         cause = sthv_pkg::CAUSE_TRUNCATED;
      end else if (!oem && (upd.sum != 8'd0)) begin
         cause = sthv_pkg::CAUSE_CHECKSUM;
      end else begin
         cause = sthv_pkg::CAUSE_NONE;
      end
   end

   always_comb begin
      verdict.table_ok     = (cause == sthv_pkg::CAUSE_NONE);
      verdict.fail_cause   = cause;
      verdict.oem_table    = oem;
      verdict.table_length = (total >= 33'd8) ? upd.length : 32'd0;
   end

endmodule

FILE: rtl/system_table_header_validator.sv
// Checks one system table per run of bytes: one byte per req transaction, req_tlast on the
// table's final byte. Bytes are taken back to back, one per cycle unless a final byte is held
// in the input stage, and each gets a single registered stage that adds it to the 8-bit sum and
// compares it against the header fields. The verdict for a table is registered in the result
// register when its final byte leaves the input stage, and is offered on rsp from then on.
// The result register lets the next table stream in while a verdict waits to be
// taken; only that table's final byte is held in the input stage until the result register
// is free. Register writes on csr take effect immediately and should be made while no table
// is in progress.
`include "system_table_header_validator_defines.svh"

module system_table_header_validator #(
   parameter int HEADER_BYTES = 36
) (
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] table_byte
   input  logic        req_tlast,    // final_byte
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,    // [0] table_ok, [3:1] fail_cause, [35:4] table_length, zero pad
   output logic        rsp_tuser,    // oem_table
   // register writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [31:0] csr_data
);

   logic        match_mode_ff, match_mode_in;
   logic [31:0] expected_sig_ff, expected_sig_in;
   logic        s1_valid_ff, s1_valid_in;
   logic [7:0]  s1_byte_ff, s1_byte_in;
   logic        s1_final_ff, s1_final_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        advance;
   logic        load;
   sthv_pkg::table_state_type state_ff, state_in, state_upd;
   sthv_pkg::verdict_type     verdict, rsp_ff, rsp_in;

   // configuration registers
   assign csr_ready = 1'b1;
   always_comb begin
      match_mode_in   = match_mode_ff;
      expected_sig_in = expected_sig_ff;
      if (csr_valid) begin
         case (csr_index)
            sthv_pkg::CSR_MATCH_MODE:   match_mode_in = csr_data[0];
            sthv_pkg::CSR_EXPECTED_SIG: expected_sig_in = csr_data;
            default: ;
         endcase
      end
   end

   // input stage handshake
   assign advance    = s1_valid_ff && (!s1_final_ff || !rsp_valid_ff || rsp_tready);
   assign load       = advance && s1_final_ff;
   assign req_tready = !s1_valid_ff || advance;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_byte_in  = s1_byte_ff;
      s1_final_in = s1_final_ff;
      if (req_tready) begin
         s1_valid_in = req_tvalid;
         s1_byte_in  = req_tdata;
         s1_final_in = req_tlast;
      end
   end

   // byte update and verdict logic
   sthv_verdict #(
      .HEADER_BYTES(HEADER_BYTES)
   ) u_verdict (
      .cur                (state_ff),
      .table_byte         (s1_byte_ff),
      .match_mode         (match_mode_ff),
      .expected_signature (expected_sig_ff),
      .upd                (state_upd),
      .verdict            (verdict)
   );

   // tracking state restarts after each verdict
   always_comb begin
      state_in = state_ff;
      if (advance) begin
         state_in = s1_final_ff ? '0 : state_upd;
      end
   end

   // result register
   assign rsp_valid_in = load || (rsp_valid_ff && !rsp_tready);
   assign rsp_in       = load ? verdict : rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         match_mode_ff   <= 1'b0;
         expected_sig_ff <= 32'd0;
         s1_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         state_ff        <= '0;
      end else begin
         match_mode_ff   <= match_mode_in;
         expected_sig_ff <= expected_sig_in;
         s1_valid_ff     <= s1_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
         state_ff        <= state_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      s1_byte_ff  <= s1_byte_in;
      s1_final_ff <= s1_final_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_ff.table_length, rsp_ff.fail_cause, rsp_ff.table_ok};
   assign rsp_tuser  = rsp_ff.oem_table;

   // checks
   `STHV_ASSERT_NOW(a_load_slot_free, load, !rsp_valid_ff || rsp_tready,
      "verdict loaded over an untaken result")
   `STHV_ASSERT_NEXT(a_restart_after_final, load,
      state_ff.byte_offset == 32'd0 && state_ff.sum == 8'd0 && !state_ff.bad_char,
      "tracking state not cleared after a verdict")
   `STHV_ASSERT_NEXT(a_no_spurious_result, !load && !rsp_valid_ff, !rsp_valid_ff,
      "result appeared without a final byte")
   `STHV_ASSERT_NOW(a_ok_matches_cause, rsp_valid_ff,
      rsp_ff.table_ok == (rsp_ff.fail_cause == sthv_pkg::CAUSE_NONE),
      "table_ok disagrees with fail_cause")

endmodule

FILE: sim/system_table_header_checker.sv
`timescale 1ns / 100ps

// watches the request, result and register channels, predicts every verdict and
// compares it with the one the validator gives
module system_table_header_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] table_byte
   input  logic        req_tlast,    // final_byte
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,    // [0] table_ok, [3:1] fail_cause, [35:4] table_length
   input  logic        rsp_tuser,    // oem_table
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [31:0] csr_data,
   output int          fail_count,
   output int          verdicts_pending
);

   localparam int HEADER_BYTES = 36;

   // register copies
   logic        mode_exact;
   logic [31:0] sig_expected;

   // per-table tracking
   logic [31:0] offset_q;
   logic [31:0] sig_q;
   logic [31:0] len_q;
   logic [7:0]  sum_q;
   logic        bad_q;

   sthv_pkg::verdict_type verdict_queue[$];

   function automatic logic legal_char(input logic [7:0] c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == "_" || c == "!";
   endfunction

   task automatic report_mismatch(input string field, input logic [39:0] want,
                                  input logic [39:0] got);
      $display("%0t mismatch on %s: expected %0h, got %0h", $realtime, field, want, got);
      fail_count++;
   endtask

   // fold one table byte into the tracking state, queue a verdict on the final byte
   task automatic absorb_byte(input logic [7:0] b, input logic last);
      logic [31:0]              off;
      logic [32:0]              total;
      logic                     oem;
      sthv_pkg::fail_cause_type cause;
      sthv_pkg::verdict_type    v;
      off = offset_q;
      if (off < 4) begin
         sig_q = sig_q | ({24'd0, b} << (8 * off[1:0]));
         if (!legal_char(b)) bad_q = 1'b1;
      end else if (off < 8) begin
         len_q = len_q | ({24'd0, b} << (8 * off[1:0]));
      end
      if (off < 8 || off < len_q) sum_q = sum_q + b;
      if (offset_q != sthv_pkg::OFFSET_MAX) offset_q = offset_q + 32'd1;
      if (last) begin
         total = {1'b0, off} + 33'd1;
         oem = (total >= 3) && (sig_q[23:0] == sthv_pkg::OEM_PREFIX);
         // checks in priority order
         if (total < 4) cause = sthv_pkg::CAUSE_TRUNCATED;
         else if (mode_exact && sig_q != sig_expected) cause = sthv_pkg::CAUSE_SIG_MISMATCH;
         else if (!mode_exact && bad_q) cause = sthv_pkg::CAUSE_BAD_CHAR;
         else if (total < 8) cause = sthv_pkg::CAUSE_TRUNCATED;
         else if (len_q < HEADER_BYTES) cause = sthv_pkg::CAUSE_TOO_SMALL;
         else if (total < {1'b0, len_q}) cause = sthv_pkg::CAUSE_TRUNCATED;
         else if (!oem && sum_q != 8'd0) cause = sthv_pkg::CAUSE_CHECKSUM;
         else cause = sthv_pkg::CAUSE_NONE;
         v.table_ok     = (cause == sthv_pkg::CAUSE_NONE);
         v.fail_cause   = cause;
         v.oem_table    = oem;
         v.table_length = (total >= 8) ? len_q : 32'd0;
         verdict_queue.push_back(v);
         offset_q = '0;
         sig_q    = '0;
         len_q    = '0;
         sum_q    = '0;
         bad_q    = 1'b0;
      end
   endtask

   // compare one result transaction with the oldest verdict
   task automatic check_verdict();
      sthv_pkg::verdict_type want;
      if (verdict_queue.size() == 0) begin
         report_mismatch("unexpected verdict", 40'd0, rsp_tdata);
         return;
      end
      want = verdict_queue.pop_front();
      if (rsp_tdata[0] !== want.table_ok)
         report_mismatch("table_ok", want.table_ok, rsp_tdata[0]);
      if (rsp_tdata[3:1] !== want.fail_cause)
         report_mismatch("fail_cause", want.fail_cause, rsp_tdata[3:1]);
      if (rsp_tdata[35:4] !== want.table_length)
         report_mismatch("table_length", want.table_length, rsp_tdata[35:4]);
      if (rsp_tdata[39:36] !== 4'd0)
         report_mismatch("padding", 40'd0, rsp_tdata[39:36]);
      if (rsp_tuser !== want.oem_table)
         report_mismatch("oem_table", want.oem_table, rsp_tuser);
   endtask

   // channel monitor
   always @(posedge clock) begin
      if (reset) begin
         mode_exact   = 1'b0;
         sig_expected = '0;
         offset_q     = '0;
         sig_q        = '0;
         len_q        = '0;
         sum_q        = '0;
         bad_q        = 1'b0;
         fail_count   = 0;
         verdict_queue.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               sthv_pkg::CSR_MATCH_MODE:   mode_exact = csr_data[0];
               sthv_pkg::CSR_EXPECTED_SIG: sig_expected = csr_data;
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) check_verdict();
         if (req_tvalid && req_tready) absorb_byte(req_tdata, req_tlast);
      end
      verdicts_pending <= verdict_queue.size();
   end

endmodule

FILE: sim/tb_system_table_header_validator.sv
`timescale 1ns / 100ps

module tb_system_table_header_validator;

   typedef logic [7:0] table_bytes_type[$];

   localparam int WATCHDOG_LIMIT = 5000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [0:0]  csr_index = 1'b0;
   logic [31:0] csr_data = 32'd0;

   int fail_count;
   int verdicts_pending;
   int send_idle = 21;
   int recv_idle = 48;
   int quiet_cycles = 0;

   system_table_header_validator dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   system_table_header_checker verdict_check (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data),
      .fail_count(fail_count), .verdicts_pending(verdicts_pending)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // result side back-pressure
   always @(posedge clock) begin
      rsp_tready <= !reset && ($urandom_range(99) >= recv_idle);
   end

   // watchdog on cycles with no transaction on any channel
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   // random signature made of legal characters only
   function automatic logic [31:0] legal_sig();
      logic [31:0] s;
      int r;
      for (int i = 0; i < 4; i++) begin
         r = $urandom_range(53);
         if (r < 26) s[8*i +: 8] = 8'h41 + r[7:0];
         else if (r < 52) s[8*i +: 8] = 8'h61 + r[7:0] - 8'd26;
         else if (r == 52) s[8*i +: 8] = sthv_pkg::CHAR_UNDERSCORE;
         else s[8*i +: 8] = sthv_pkg::CHAR_BANG;
      end
      return s;
   endfunction

   // header plus random body, optionally with the checksum byte made good
   function automatic table_bytes_type build_table(input logic [31:0] sig, input logic [31:0] len,
                                                   input int count, input bit fix_sum);
      table_bytes_type t;
      logic [7:0] s;
      for (int i = 0; i < count; i++) begin
         if (i < 4) t.push_back(sig[8*i +: 8]);
         else if (i < 8) t.push_back(len[8*(i-4) +: 8]);
         else t.push_back(8'($urandom_range(255)));
      end
      if (fix_sum && count > 9 && len > 9) begin
         s = 8'd0;
         for (int i = 0; i < count; i++)
            if ((i < 8 || i < len) && i != 9) s = s + t[i];
         t[9] = 8'd0 - s;
      end
      return t;
   endfunction

   // one request transaction, with random gaps in front
   task automatic send_byte(input logic [7:0] b, input logic last);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic send_table(input table_bytes_type t);
      foreach (t[i]) send_byte(t[i], i == t.size() - 1);
   endtask

   // hold off until every verdict is back and the pipeline has drained
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (verdicts_pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input sthv_pkg::csr_index_type idx, input logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic configure(input logic mode, input logic [31:0] sig);
      wait_idle();
      write_csr(sthv_pkg::CSR_MATCH_MODE, {31'd0, mode});
      write_csr(sthv_pkg::CSR_EXPECTED_SIG, sig);
      csr_valid <= 1'b0;
   endtask

   // stimulus
   initial begin
      logic [31:0] sig;
      logic [31:0] len;
      logic [31:0] exp_sig;
      logic        mode;
      int count;
      int kind;
      int seg_items;
      bit fix;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: short streams and a length below the header size
      send_table(build_table(32'h0000_0041, 32'd0, 1, 0));
      send_table(build_table({8'h00, sthv_pkg::OEM_PREFIX}, 32'd0, 3, 0));
      send_table(build_table(32'h4241_FF00, 32'd0, 4, 0));
      send_table(build_table("DCBA", 32'd0, 4, 0));
      send_table(build_table("PCAF", 32'd16, 8, 0));

      for (int seg = 0; seg < 6; seg++) begin
         case (seg / 2)
            0: begin send_idle = 21; recv_idle = 48; end
            1: begin send_idle = 48; recv_idle = 21; end
            default: begin send_idle = 0; recv_idle = 0; end
         endcase
         case (seg)
            0: begin mode = 1'b0; exp_sig = $urandom(); end
            1: begin mode = 1'b1; exp_sig = legal_sig(); end
            2: begin mode = 1'b1; exp_sig = 32'hFFFF_FFFF; end
            3: begin mode = 1'b0; exp_sig = 32'd0; end
            4: begin mode = 1'b1; exp_sig = 32'd0; end
            default: begin mode = 1'b1; exp_sig = legal_sig(); end
         endcase
         configure(mode, exp_sig);
         seg_items = 0;
         while (seg_items < 280) begin
            kind = $urandom_range(99);
            sig = (mode && $urandom_range(9) != 0) ? exp_sig : legal_sig();
            len = $urandom_range(72, 36);
            fix = 0;
            if (kind < 55) begin
               // well-formed, sometimes with extra bytes or a bad sum
               count = len + (($urandom_range(3) == 0) ? $urandom_range(6, 1) : 0);
               fix = ($urandom_range(9) != 0);
            end else if (kind < 65) begin
               // oem table, checksum not checked
               sig[23:0] = sthv_pkg::OEM_PREFIX;
               count = len + $urandom_range(2);
            end else if (kind < 75) begin
               // body cut short
               count = $urandom_range(len - 1, 8);
            end else if (kind < 85) begin
               // header cut short, or header alone
               if ($urandom_range(1)) sig = $urandom();
               count = $urandom_range(8, 1);
            end else if (kind < 92) begin
               // declared length below the header size
               len = $urandom_range(35);
               count = $urandom_range(40, 8);
               fix = 1;
            end else begin
               // arbitrary header words
               sig = $urandom();
               len = $urandom();
               count = $urandom_range(48, 8);
            end
            send_table(build_table(sig, len, count, fix));
            seg_items += count;
         end
      end

      wait_idle();
      repeat (16) @(posedge clock);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
